// ===== sv/pn3d_pkg.sv =====
// Shared types and constants for the 3D gradient noise core.
// No dependencies; imported by every module of the block except the queue.
package pn3d_pkg;

  localparam int TableSizeDef = 256;
  localparam int FracBitsDef  = 16;
  localparam int CoordW       = 32;
  localparam int ByteW        = 8;
  localparam int HashW        = 4;
  localparam int OutW         = 18;
  localparam int OutFrac      = 16;

  typedef enum logic {
    ActLoad = 1'b0,
    ActEval = 1'b1
  } action_e;

  // width of one queued word: action, index, reduced byte, hash nibble, cells, fractions
  function automatic int item_width(int aw, int fb);
    return 1 + 2 * aw + HashW + 3 * aw + 3 * fb;
  endfunction

endpackage

// ===== sv/pn3d_front.sv =====
// Front end: accepts words, splits coordinates into wrapped cell and fraction,
// reduces table bytes. Depends on pn3d_pkg.
module pn3d_front #(
  parameter int TableSize = pn3d_pkg::TableSizeDef,
  parameter int FracBits  = pn3d_pkg::FracBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  action_i,
  input  logic [pn3d_pkg::ByteW-1:0]            table_index_i,
  input  logic [pn3d_pkg::ByteW-1:0]            table_value_i,
  input  logic signed [pn3d_pkg::CoordW-1:0]    coord_x_i,
  input  logic signed [pn3d_pkg::CoordW-1:0]    coord_y_i,
  input  logic signed [pn3d_pkg::CoordW-1:0]    coord_z_i,
  output logic                                  push_o,
  output logic [pn3d_pkg::item_width($clog2(TableSize), FracBits)-1:0] item_o,
  input  logic                                  full_i
);
  import pn3d_pkg::*;

  localparam int AW  = $clog2(TableSize);
  localparam int FB  = FracBits;
  localparam int N   = CoordW - FB;
  localparam int SH  = N + 8;
  localparam int RW  = SH - 3;
  localparam logic [RW-1:0] Recip =
    RW'(((64'd1 << SH) + 64'(TableSize) - 64'd1) / 64'(TableSize));
  localparam int VSH = 16;
  localparam int VRW = 13;
  localparam logic [VRW-1:0] VRecip =
    VRW'(((64'd1 << VSH) + 64'(TableSize) - 64'd1) / 64'(TableSize));

  typedef struct packed {
    action_e           act;
    logic [AW-1:0]     idx;
    logic [AW-1:0]     vmod;
    logic [HashW-1:0]  vraw;
    logic [AW-1:0]     cx;
    logic [AW-1:0]     cy;
    logic [AW-1:0]     cz;
    logic [FB-1:0]     fx;
    logic [FB-1:0]     fy;
    logic [FB-1:0]     fz;
  } item_t;

  logic adv;
  logic [CoordW-1:0] coord [3];
  logic [N-1:0]      mag_d [3];

  logic              f0_vld_q, f1_vld_q, f2_vld_q;
  action_e           f0_act_q, f1_act_q, f2_act_q;
  logic              f0_ok_q, f1_ok_q, f2_ok_q;
  logic [AW-1:0]     f0_idx_q, f1_idx_q, f2_idx_q;
  logic [ByteW-1:0]  f0_val_q, f1_val_q;
  logic [HashW-1:0]  f2_vraw_q;
  logic [AW-1:0]     f2_vmod_q;
  logic [ByteW+VRW-1:0] f1_vprod_q;
  logic              f0_neg_q [3];
  logic              f1_neg_q [3];
  logic              f2_neg_q [3];
  logic [N-1:0]      f0_mag_q [3];
  logic [N-1:0]      f1_mag_q [3];
  logic [N+RW-1:0]   f1_prod_q [3];
  logic [AW-1:0]     f2_rem_q [3];
  logic [FB-1:0]     f0_frac_q [3];
  logic [FB-1:0]     f1_frac_q [3];
  logic [FB-1:0]     f2_frac_q [3];
  logic [N-1:0]      quo [3];
  logic [N-1:0]      rem_d [3];
  logic [ByteW-1:0]  vquo, vrem;
  logic [AW-1:0]     cell_w [3];
  item_t             push_item;

  assign adv        = !full_i;
  assign in_ready_o = adv;
  assign coord[0]   = coord_x_i;
  assign coord[1]   = coord_y_i;
  assign coord[2]   = coord_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = coord[i][CoordW-1] ? N'(-coord[i][CoordW-1:FB]) : coord[i][CoordW-1:FB];
      quo[i]   = N'(f1_prod_q[i] >> SH);
      rem_d[i] = f1_mag_q[i] - N'(quo[i] * N'(TableSize));
    end
    vquo = ByteW'(f1_vprod_q >> VSH);
    vrem = f1_val_q - ByteW'(vquo * ByteW'(TableSize));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_vld_q <= 1'b0;
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
    end else if (adv) begin
      f0_vld_q <= in_valid_i;
      f1_vld_q <= f0_vld_q;
      f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f0_act_q   <= action_e'(action_i);
      f0_ok_q    <= (ByteW + 1)'(table_index_i) < (ByteW + 1)'(TableSize);
      f0_idx_q   <= table_index_i[AW-1:0];
      f0_val_q   <= table_value_i;
      f1_act_q   <= f0_act_q;
      f1_ok_q    <= f0_ok_q;
      f1_idx_q   <= f0_idx_q;
      f1_val_q   <= f0_val_q;
      f1_vprod_q <= (ByteW + VRW)'(f0_val_q) * (ByteW + VRW)'(VRecip);
      f2_act_q   <= f1_act_q;
      f2_ok_q    <= f1_ok_q;
      f2_idx_q   <= f1_idx_q;
      f2_vraw_q  <= f1_val_q[HashW-1:0];
      f2_vmod_q  <= AW'(vrem);
      for (int i = 0; i < 3; i++) begin
        f0_neg_q[i]  <= coord[i][CoordW-1];
        f0_mag_q[i]  <= mag_d[i];
        f0_frac_q[i] <= coord[i][FB-1:0];
        f1_neg_q[i]  <= f0_neg_q[i];
        f1_mag_q[i]  <= f0_mag_q[i];
        f1_prod_q[i] <= (N + RW)'(f0_mag_q[i]) * (N + RW)'(Recip);
        f1_frac_q[i] <= f0_frac_q[i];
        f2_neg_q[i]  <= f1_neg_q[i];
        f2_rem_q[i]  <= AW'(rem_d[i]);
        f2_frac_q[i] <= f1_frac_q[i];
      end
    end
  end

  // negative cells wrap back from the top of the table
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cell_w[i] = (f2_neg_q[i] && f2_rem_q[i] != '0)
                ? AW'((AW + 1)'(TableSize) - (AW + 1)'(f2_rem_q[i])) : f2_rem_q[i];
    end
    push_item.act  = f2_act_q;
    push_item.idx  = f2_idx_q;
    push_item.vmod = f2_vmod_q;
    push_item.vraw = f2_vraw_q;
    push_item.cx   = cell_w[0];
    push_item.cy   = cell_w[1];
    push_item.cz   = cell_w[2];
    push_item.fx   = f2_frac_q[0];
    push_item.fy   = f2_frac_q[1];
    push_item.fz   = f2_frac_q[2];
  end

  // out-of-range loads are dropped here
  assign push_o = f2_vld_q && adv && (f2_act_q == ActEval || f2_ok_q);
  assign item_o = push_item;

endmodule

// ===== sv/pn3d_queue.sv =====
// Two-entry queue between the front end and the evaluation pipeline.
// No dependencies; generic width.
module pn3d_queue #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue pushed while full");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue popped while empty");
  a_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + 2'd1) else $error("queue count slip");

endmodule

// ===== sv/pn3d_back.sv =====
// Evaluation pipeline: table walk over replicated permutation copies, fade,
// gradients, trilinear blend, output register. Depends on pn3d_pkg.
module pn3d_back #(
  parameter int TableSize = pn3d_pkg::TableSizeDef,
  parameter int FracBits  = pn3d_pkg::FracBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  output logic                              pop_o,
  input  logic                              empty_i,
  input  logic [pn3d_pkg::item_width($clog2(TableSize), FracBits)-1:0] item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [pn3d_pkg::OutW-1:0]  noise_value_o
);
  import pn3d_pkg::*;

  localparam int AW   = $clog2(TableSize);
  localparam int FB   = FracBits;
  localparam int One  = 1 << FB;
  localparam int Half = 1 << (FB - 1);
  localparam int TW   = FB + 1;
  localparam int GW   = FB + 2;
  localparam int VW   = FB + 3;
  localparam int DW   = FB + 4;
  localparam int PW   = TW + 1 + DW;
  localparam int SxW  = FB + 6;
  localparam int M1W  = 2 * FB + 7;
  localparam int EW   = FB + 20;
  localparam int DnSh = (FB > OutFrac) ? FB - OutFrac : 0;
  localparam int UpSh = (FB < OutFrac) ? OutFrac - FB : 0;
  localparam longint RndBias = (DnSh > 0) ? (longint'(1) << (DnSh - 1)) : longint'(0);
  localparam int OutMax = (1 << (OutW - 1)) - 1;
  localparam int OutMin = -(1 << (OutW - 1));
  localparam logic [HashW-1:0] GradSplitU = 4'd8;
  localparam logic [HashW-1:0] GradSplitV = 4'd4;
  localparam logic [HashW-1:0] GradSwapA  = 4'd12;
  localparam logic [HashW-1:0] GradSwapB  = 4'd14;

  typedef struct packed {
    action_e           act;
    logic [AW-1:0]     idx;
    logic [AW-1:0]     vmod;
    logic [HashW-1:0]  vraw;
    logic [AW-1:0]     cx;
    logic [AW-1:0]     cy;
    logic [AW-1:0]     cz;
    logic [FB-1:0]     fx;
    logic [FB-1:0]     fy;
    logic [FB-1:0]     fz;
  } item_t;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] s;
    s = (AW + 1)'(a) + (AW + 1)'(b);
    if (s >= (AW + 1)'(TableSize)) s = s - (AW + 1)'(TableSize);
    return AW'(s);
  endfunction

  function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] a);
    return (a == AW'(TableSize - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic signed [VW-1:0] grad(logic [HashW-1:0] h,
      logic signed [GW-1:0] x, logic signed [GW-1:0] y, logic signed [GW-1:0] z);
    logic signed [GW-1:0] u, v;
    logic signed [VW-1:0] gu, gv;
    u  = (h < GradSplitU) ? x : y;
    v  = (h < GradSplitV) ? y : ((h == GradSwapA || h == GradSwapB) ? x : z);
    gu = h[0] ? -VW'(u) : VW'(u);
    gv = h[1] ? -VW'(v) : VW'(v);
    return gu + gv;
  endfunction

  function automatic logic signed [PW-1:0] wmul(logic [TW-1:0] t,
      logic signed [VW-1:0] a, logic signed [VW-1:0] b);
    logic signed [DW-1:0] d;
    d = DW'(b) - DW'(a);
    return PW'($signed({1'b0, t})) * PW'(d);
  endfunction

  function automatic logic signed [VW-1:0] radd(logic signed [VW-1:0] a,
      logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    r = (p + $signed(PW'(Half))) >>> FB;
    return a + VW'(r);
  endfunction

  logic adv;
  logic [8:0] vld_q;
  logic       out_vld_q;
  logic signed [OutW-1:0] noise_q;
  item_t      b0_q, b1_q, b2_q, b0_in;

  logic [AW-1:0]    mem0 [TableSize];
  logic [AW-1:0]    mem1 [2][TableSize];
  logic [HashW-1:0] mem2 [4][TableSize];

  logic [AW-1:0]    p1_q [2];
  logic [AW-1:0]    p2_q [4];
  logic [HashW-1:0] h_q [8];
  logic [AW-1:0]    a1_addr [2];
  logic [AW-1:0]    a2_addr [4];

  logic [FB-1:0]           frac0 [3];
  logic [FB-1:0]           frac1 [3];
  logic [FB-1:0]           frac2 [3];
  logic [FB-1:0]           tt_q [3];
  logic signed [SxW-1:0]   pl_q [3];
  logic [FB-1:0]           cube_q [3];
  logic signed [SxW-1:0]   poly_q [3];
  logic [TW-1:0]           wt_q [3];
  logic [FB-1:0]           fr3_q [3];

  logic [TW-1:0]           v4_q, v5_q, w4_q, w5_q, w6_q, w7_q;
  logic signed [PW-1:0]    px_q [4];
  logic signed [VW-1:0]    ax_q [4];
  logic signed [VW-1:0]    bx_q [4];
  logic signed [PW-1:0]    py_q [2];
  logic signed [VW-1:0]    ay_q [2];
  logic signed [VW-1:0]    by_q [2];
  logic signed [PW-1:0]    pz_q;
  logic signed [VW-1:0]    az_q;

  logic signed [VW-1:0]    gr [8];
  logic signed [GW-1:0]    cmp [3][2];
  logic signed [VW-1:0]    fin;
  logic signed [EW-1:0]    ext, scl;
  logic signed [OutW-1:0]  sat;

  assign adv           = !out_vld_q || out_ready_i;
  assign pop_o         = adv && !empty_i;
  assign b0_in         = item_i;
  assign out_valid_o   = out_vld_q;
  assign noise_value_o = noise_q;

  assign frac0[0] = b0_q.fx;
  assign frac0[1] = b0_q.fy;
  assign frac0[2] = b0_q.fz;
  assign frac1[0] = b1_q.fx;
  assign frac1[1] = b1_q.fy;
  assign frac1[2] = b1_q.fz;
  assign frac2[0] = b2_q.fx;
  assign frac2[1] = b2_q.fy;
  assign frac2[2] = b2_q.fz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[7:3], vld_q[2] && b2_q.act == ActEval, vld_q[1:0], !empty_i};
      out_vld_q <= vld_q[8];
    end
  end

  // table walk addresses
  always_comb begin
    a1_addr[0] = wrap_add(p1_q[0], b1_q.cy);
    a1_addr[1] = wrap_add(p1_q[1], b1_q.cy);
    a2_addr[0] = wrap_add(p2_q[0], b2_q.cz);
    a2_addr[1] = wrap_add(p2_q[2], b2_q.cz);
    a2_addr[2] = wrap_add(p2_q[1], b2_q.cz);
    a2_addr[3] = wrap_add(p2_q[3], b2_q.cz);
  end

  // each copy is written when a load word passes the stage that reads it
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (vld_q[0] && b0_q.act == ActLoad) mem0[b0_q.idx] <= b0_q.vmod;
      if (vld_q[1] && b1_q.act == ActLoad) begin
        for (int c = 0; c < 2; c++) mem1[c][b1_q.idx] <= b1_q.vmod;
      end
      if (vld_q[2] && b2_q.act == ActLoad) begin
        for (int c = 0; c < 4; c++) mem2[c][b2_q.idx] <= b2_q.vraw;
      end
      p1_q[0] <= mem0[b0_q.cx];
      p1_q[1] <= mem0[wrap_inc(b0_q.cx)];
      for (int c = 0; c < 2; c++) begin
        p2_q[2*c]     <= mem1[c][a1_addr[c]];
        p2_q[2*c + 1] <= mem1[c][wrap_inc(a1_addr[c])];
      end
      for (int c = 0; c < 4; c++) begin
        h_q[c]     <= mem2[c][a2_addr[c]];
        h_q[c + 4] <= mem2[c][wrap_inc(a2_addr[c])];
      end
    end
  end

  // fade 6t^5-15t^4+10t^3 as t^3 * (t*(6t-15)+10)
  always_ff @(posedge clk_i) begin
    logic signed [SxW-1:0] six;
    logic signed [M1W-1:0] m1;
    logic [2*FB-1:0]       sq, cb;
    logic [2*FB+4:0]       m3;
    logic [FB+4:0]         r3;
    if (adv) begin
      b0_q <= b0_in;
      b1_q <= b0_q;
      b2_q <= b1_q;
      for (int i = 0; i < 3; i++) begin
        six = SxW'(6) * $signed(SxW'(frac0[i])) - $signed(SxW'(15 * One));
        m1  = M1W'($signed({1'b0, frac0[i]})) * M1W'(six);
        sq  = (2 * FB)'(frac0[i]) * (2 * FB)'(frac0[i]);
        tt_q[i] <= FB'((sq + (2 * FB)'(Half)) >> FB);
        pl_q[i] <= SxW'((m1 + $signed(M1W'(Half))) >>> FB);
        cb  = (2 * FB)'(tt_q[i]) * (2 * FB)'(frac1[i]);
        cube_q[i] <= FB'((cb + (2 * FB)'(Half)) >> FB);
        poly_q[i] <= pl_q[i] + $signed(SxW'(10 * One));
        m3  = (2 * FB + 5)'(cube_q[i]) * (2 * FB + 5)'(poly_q[i][SxW-2:0]);
        r3  = (FB + 5)'((m3 + (2 * FB + 5)'(Half)) >> FB);
        wt_q[i]  <= (r3 > (FB + 5)'(One)) ? TW'(One) : TW'(r3);
        fr3_q[i] <= frac2[i];
      end
    end
  end

  // corner offsets and gradients
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmp[i][0] = $signed({2'b00, fr3_q[i]});
      cmp[i][1] = cmp[i][0] - $signed(GW'(One));
    end
    for (int k = 0; k < 8; k++) begin
      gr[k] = grad(h_q[k], cmp[0][k & 1], cmp[1][(k >> 1) & 1], cmp[2][(k >> 2) & 1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        px_q[j] <= wmul(wt_q[0], gr[2*j], gr[2*j + 1]);
        ax_q[j] <= gr[2*j];
        bx_q[j] <= radd(ax_q[j], px_q[j]);
      end
      v4_q <= wt_q[1];
      w4_q <= wt_q[2];
      v5_q <= v4_q;
      w5_q <= w4_q;
      for (int j = 0; j < 2; j++) begin
        py_q[j] <= wmul(v5_q, bx_q[2*j], bx_q[2*j + 1]);
        ay_q[j] <= bx_q[2*j];
        by_q[j] <= radd(ay_q[j], py_q[j]);
      end
      w6_q <= w5_q;
      w7_q <= w6_q;
      pz_q <= wmul(w7_q, by_q[0], by_q[1]);
      az_q <= by_q[0];
      noise_q <= sat;
    end
  end

  // rescale to 16 fraction bits and saturate
  always_comb begin
    fin = radd(az_q, pz_q);
    ext = EW'(fin);
    scl = ((ext + $signed(EW'(RndBias))) >>> DnSh) <<< UpSh;
    if (scl > $signed(EW'(OutMax)))      sat = OutW'(OutMax);
    else if (scl < $signed(EW'(OutMin))) sat = OutW'(OutMin);
    else                                 sat = OutW'(scl);
  end

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q)) else $error("pipeline moved while stalled");
  a_weight_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> (wt_q[0] <= TW'(One) && wt_q[1] <= TW'(One) && wt_q[2] <= TW'(One)))
    else $error("fade weight above one");
  a_loads_retire : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] && b2_q.act == ActLoad && adv |=> !vld_q[3])
    else $error("load word entered the blend stages");

endmodule

// ===== sv/perlin_noise_3d_core.sv =====
// Improved 3D gradient noise core: front end, word queue, evaluation pipeline.
// Depends on pn3d_pkg, pn3d_front, pn3d_queue, pn3d_back.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  input    | in_valid_i / in_ready_o   | action_i, table_index_i, table_value_i,
//           |                           | coord_x_i, coord_y_i, coord_z_i
//  output   | out_valid_o / out_ready_i | noise_value_o
//
// One word accepted per cycle while the queue is not full; one result per cycle sustained while out_ready_i stays high.
// A result passes through 3 front stages, the queue, 9 pipeline stages and then
// the output register.
// The permutation table is replicated (seven copies, two read ports each), so the
// three-level table walk takes one pipeline stage per level.
// Reset clears control only; table contents are undefined until loaded.
// An output stall halts the evaluation pipeline; the queue lets the front run on until it is full.
module perlin_noise_3d_core #(
  parameter int TableSize = pn3d_pkg::TableSizeDef,
  parameter int FracBits  = pn3d_pkg::FracBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               action_i,
  input  logic [pn3d_pkg::ByteW-1:0]         table_index_i,
  input  logic [pn3d_pkg::ByteW-1:0]         table_value_i,
  input  logic signed [pn3d_pkg::CoordW-1:0] coord_x_i,
  input  logic signed [pn3d_pkg::CoordW-1:0] coord_y_i,
  input  logic signed [pn3d_pkg::CoordW-1:0] coord_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [pn3d_pkg::OutW-1:0]   noise_value_o
);
  import pn3d_pkg::*;

  localparam int ItemW = item_width($clog2(TableSize), FracBits);

  logic             push, full, pop, empty;
  logic [ItemW-1:0] push_word, head_word;

  pn3d_front #(.TableSize(TableSize), .FracBits(FracBits)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .table_index_i,
    .table_value_i, .coord_x_i, .coord_y_i, .coord_z_i,
    .push_o(push), .item_o(push_word), .full_i(full)
  );

  pn3d_queue #(.Width(ItemW)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_word), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(head_word)
  );

  pn3d_back #(.TableSize(TableSize), .FracBits(FracBits)) u_back (
    .clk_i, .rst_ni, .pop_o(pop), .empty_i(empty), .item_i(head_word),
    .out_valid_o, .out_ready_i, .noise_value_o
  );

endmodule

// ===== tb/sv/perlin_noise_3d_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for perlin_noise_3d_core: loads the permutation table,
// then runs directed and random evaluations and table loads against a predictor of the noise.
// Depends on pn3d_pkg and the core RTL.
module perlin_noise_3d_core_tb;
  import pn3d_pkg::*;

  localparam longint One = longint'(1) << FracBitsDef;

  typedef struct {
    action_e           act;
    logic [7:0]        idx;
    logic [7:0]        val;
    logic signed [31:0] x, y, z;
    bit                typed;
    logic signed [17:0] want;
  } word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic action_i = 1'b0;
  logic [7:0] table_index_i = '0;
  logic [7:0] table_value_i = '0;
  logic signed [31:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [17:0] noise_value_o;

  logic [7:0] perm_copy [256];
  logic signed [17:0] noise_due [$];
  int  fails = 0;
  bit  calm = 0;

  always #2 clk_i = ~clk_i;

  perlin_noise_3d_core DUT (.*);

  function automatic longint mul_round(longint a, longint b);
    return (a * b + (One >>> 1)) >>> FracBitsDef;
  endfunction

  function automatic longint fade_w(longint t);
    longint poly, cube, r;
    poly = mul_round(t, 6 * t - 15 * One) + 10 * One;
    cube = mul_round(mul_round(t, t), t);
    r = mul_round(cube, poly);
    if (r < 0) r = 0;
    if (r > One) r = One;
    return r;
  endfunction

  function automatic longint lerp_q(longint t, longint a, longint b);
    return a + mul_round(t, b - a);
  endfunction

  function automatic longint grad_dot(logic [7:0] hb, longint x, longint y, longint z);
    logic [3:0] h;
    longint u, v;
    h = hb[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic [7:0] pt(int i);
    return perm_copy[i & 255];
  endfunction

  function automatic logic signed [17:0] noise_at(logic signed [31:0] px,
      logic signed [31:0] py, logic signed [31:0] pz);
    int cx, cy, cz, a, b, aa, ab, ba, bb;
    longint fx, fy, fz, u, v, w, x1, y1, z1, r;
    cx = (px >>> 16) & 255; fx = px[15:0];
    cy = (py >>> 16) & 255; fy = py[15:0];
    cz = (pz >>> 16) & 255; fz = pz[15:0];
    u = fade_w(fx); v = fade_w(fy); w = fade_w(fz);
    a = pt(cx) + cy; aa = pt(a) + cz; ab = pt(a + 1) + cz;
    b = pt(cx + 1) + cy; ba = pt(b) + cz; bb = pt(b + 1) + cz;
    x1 = fx - One; y1 = fy - One; z1 = fz - One;
    r = lerp_q(w,
          lerp_q(v,
            lerp_q(u, grad_dot(pt(aa), fx, fy, fz), grad_dot(pt(ba), x1, fy, fz)),
            lerp_q(u, grad_dot(pt(ab), fx, y1, fz), grad_dot(pt(bb), x1, y1, fz))),
          lerp_q(v,
            lerp_q(u, grad_dot(pt(aa + 1), fx, fy, z1), grad_dot(pt(ba + 1), x1, fy, z1)),
            lerp_q(u, grad_dot(pt(ab + 1), fx, y1, z1), grad_dot(pt(bb + 1), x1, y1, z1))));
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r[17:0];
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= w.act;
    table_index_i <= w.idx;
    table_value_i <= w.val;
    coord_x_i     <= w.x;
    coord_y_i     <= w.y;
    coord_z_i     <= w.z;
    do @(posedge clk_i); while (!in_ready_o);
    if (w.act == ActLoad) perm_copy[w.idx] = w.val;
    else noise_due.push_back(w.typed ? w.want : noise_at(w.x, w.y, w.z));
  endtask

  function automatic logic signed [31:0] rand_coord();
    int k;
    k = $urandom_range(0, 3);
    case (k)
      0: return $urandom;
      1: return {16'($urandom_range(0, 65535)), 16'h0000} |
                (($urandom & 1) ? 32'hFFFF : 32'h0);
      2: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
      default: return {16'($urandom), 16'($urandom_range(0, 3) == 0 ? 16'h0001 : 16'($urandom))};
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (noise_due.size() == 0) begin
        $error("noise_value: unexpected word %0d", noise_value_o);
        fails++;
      end else begin
        if (noise_value_o !== noise_due[0]) begin
          $error("noise_value: expected %0d, actual %0d", noise_due[0], noise_value_o);
          fails++;
        end
        void'(noise_due.pop_front());
      end
    end
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    word_t w;
    word_t rows [$];
    logic [7:0] shuf [256];
    int j;
    logic [7:0] t;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 256; i++) shuf[i] = i[7:0];
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = shuf[i]; shuf[i] = shuf[j]; shuf[j] = t;
    end
    for (int i = 0; i < 256; i++) begin
      w = '{ActLoad, i[7:0], shuf[i], 0, 0, 0, 0, 0};
      send_word(w);
    end

    // integer lattice points give zero whatever the table holds
    rows.push_back('{ActEval, 0, 0, 32'sh0, 32'sh0, 32'sh0, 1, 18'sd0});
    rows.push_back('{ActEval, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1, 18'sd0});
    rows.push_back('{ActEval, 0, 0, 32'sh7FFF0000, 32'sh7FFF0000, 32'sh7FFF0000, 1, 18'sd0});
    rows.push_back('{ActEval, 0, 0, 32'shFFFF0000, 32'sh00010000, 32'sh00FF0000, 1, 18'sd0});
    rows.push_back('{ActEval, 0, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0});
    rows.push_back('{ActEval, 0, 0, 32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF, 0, 0});
    rows.push_back('{ActEval, 0, 0, 32'sh00000001, 32'sh00000001, 32'sh00000001, 0, 0});
    rows.push_back('{ActEval, 0, 0, 32'sh00008000, 32'sh00008000, 32'sh00008000, 0, 0});
    rows.push_back('{ActEval, 0, 0, 32'sh80008000, 32'sh0000FFFF, 32'shFF008000, 0, 0});
    rows.push_back('{ActEval, 0, 0, 32'sh00FF4000, 32'sh00FFC000, 32'sh01004000, 0, 0});
    rows.push_back('{ActLoad, 8'hFF, 8'h00, 0, 0, 0, 0, 0});
    rows.push_back('{ActLoad, 8'h00, 8'hFF, 0, 0, 0, 0, 0});
    rows.push_back('{ActEval, 0, 0, 32'sh00FF8000, 32'sh00FF8000, 32'sh00FF8000, 0, 0});
    rows.push_back('{ActEval, 0, 0, 32'shFFFF8000, 32'sh00004000, 32'sh7FFFC000, 0, 0});
    foreach (rows[i]) send_word(rows[i]);

    for (int n = 0; n < 180; n++) begin
      if (n % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0)
        w = '{ActLoad, 8'($urandom), 8'($urandom), $urandom, $urandom, $urandom, 0, 0};
      else
        w = '{ActEval, 8'($urandom), 8'($urandom), rand_coord(), rand_coord(), rand_coord(),
              0, 0};
      send_word(w);
    end
    in_valid_i <= 1'b0;
    calm = 0;

    while (noise_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== perlin_noise_3d_core.f =====
sv/pn3d_pkg.sv
sv/pn3d_front.sv
sv/pn3d_queue.sv
sv/pn3d_back.sv
sv/perlin_noise_3d_core.sv
tb/sv/perlin_noise_3d_core_tb.sv
